>>> rtl/json_string_unescape_utf8_assert.svh
// assertion macros shared by the json string unescaper rtl
// each macro expects clk and arst_n in scope of the module that uses it
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
// types, codes and helper functions for the json string unescaper
// used by jsu_decode, jsu_emit and the top level; depends on nothing
package jsu_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_HEX     = 3'd2,
		MODE_LOW_BS  = 3'd3,
		MODE_LOW_U   = 3'd4,
		MODE_LOW_HEX = 3'd5
	} jsu_mode_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} jsu_kind_t;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_CONTROL     = 4'd1,
		ERR_TRUNC_ESC   = 4'd2,
		ERR_BAD_ESC     = 4'd3,
		ERR_TRUNC_HEX   = 4'd4,
		ERR_BAD_HEX     = 4'd5,
		ERR_MISSING_LOW = 4'd6,
		ERR_BAD_LOW     = 4'd7,
		ERR_LONE_LOW    = 4'd8,
		ERR_UNTERM      = 4'd9
	} jsu_err_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_BYTE  = 3'd1,
		ACT_CP    = 3'd2,
		ACT_CLOSE = 3'd3,
		ACT_FAIL  = 3'd4
	} jsu_act_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// top six bits of a high / low surrogate (D800..DBFF, DC00..DFFF)
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;
	// 0x10000 expressed in units of 1024
	localparam logic [10:0] SUPP_BASE = 11'd64;

	typedef logic [3:0][7:0] jsu_bytes_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       input_ended;
	} jsu_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		jsu_kind_t  kind;
		jsu_err_t   error_code;
		logic       last;
	} jsu_out_t;

	// all results caused by one input item
	typedef struct packed {
		logic       valid;
		logic [1:0] last_idx;
		jsu_kind_t  kind;
		jsu_err_t   code;
		jsu_bytes_t bytes;
	} jsu_group_t;

	typedef struct packed {
		logic [1:0] last_idx;
		jsu_bytes_t bytes;
	} jsu_utf8_t;

	// {ok, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {ok, mapped byte} for the single-byte escapes
	function automatic logic [8:0] esc_byte(input logic [7:0] c);
		logic [8:0] r;
		r = '0;
		unique case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0C};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h72:   r = {1'b1, 8'h0D};
			8'h74:   r = {1'b1, 8'h09};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
		jsu_utf8_t r;
		r = '0;
		if (cp <= 21'h7F) begin
			r.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp <= 21'h7FF) begin
			r.last_idx = 2'd1;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.last_idx = 2'd2;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.last_idx = 2'd3;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

>>> rtl/jsu_decode.sv
// decode stage: parser state registers and the per-byte result group
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  jsu_in_t    item,
	output jsu_group_t grp
);

	jsu_mode_t   mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hi_q, hi_d;

	logic [7:0]  c;
	logic        ended;
	logic [4:0]  hx;
	logic [15:0] v;
	logic        full, is_hi, is_lo;
	logic [8:0]  esc;
	logic [20:0] cp;
	jsu_utf8_t   enc;

	jsu_act_t    act;
	jsu_err_t    err;
	logic [7:0]  sbyte;

	assign c     = item.in_byte;
	assign ended = item.input_ended;
	assign hx    = hex_digit(c);
	assign v     = {acc_q[11:0], hx[3:0]};
	assign full  = (cnt_q == 2'd3);
	assign is_hi = (v[15:10] == HI_SURR_TAG);
	assign is_lo = (v[15:10] == LO_SURR_TAG);
	assign esc   = esc_byte(c);
	assign cp    = (mode_q == MODE_LOW_HEX) ? {({1'b0, hi_q} + SUPP_BASE), v[9:0]}
	                                        : {5'd0, v};
	assign enc   = utf8_encode(cp);

	// next state
	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		hi_d   = hi_q;
		if (ended) begin
			mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					if (esc[8]) begin
						mode_d = MODE_PLAIN;
					end else if (c == CH_U) begin
						mode_d = MODE_HEX; cnt_d = '0; acc_d = '0;
					end else begin
						mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
					end
				end
				MODE_HEX, MODE_LOW_HEX: begin
					if (hx[4] && !full) begin
						acc_d = v;
						cnt_d = cnt_q + 2'd1;
					end else if (hx[4] && mode_q == MODE_HEX && is_hi) begin
						hi_d   = v[9:0];
						mode_d = MODE_LOW_BS; cnt_d = '0; acc_d = '0;
					end else begin
						mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
					end
				end
				MODE_LOW_BS: begin
					if (c == CH_BSLASH) begin
						mode_d = MODE_LOW_U;
					end else begin
						mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
					end
				end
				MODE_LOW_U: begin
					if (c == CH_U) begin
						mode_d = MODE_LOW_HEX; cnt_d = '0; acc_d = '0;
					end else begin
						mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
					end
				end
				default: begin
					if (c == CH_QUOTE || c < CH_SPACE) begin
						mode_d = MODE_PLAIN; cnt_d = '0; acc_d = '0; hi_d = '0;
					end else if (c == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						mode_d = MODE_PLAIN;
					end
				end
			endcase
		end
	end

	// what this byte produces
	always_comb begin
		act   = ACT_NONE;
		err   = ERR_NONE;
		sbyte = c;
		if (ended) begin
			act = ACT_FAIL;
			unique case (mode_q)
				MODE_ESC:                err = ERR_TRUNC_ESC;
				MODE_HEX:                err = ERR_TRUNC_HEX;
				MODE_LOW_BS, MODE_LOW_U: err = ERR_MISSING_LOW;
				MODE_LOW_HEX:            err = ERR_BAD_LOW;
				default:                 err = ERR_UNTERM;
			endcase
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					if (esc[8]) begin
						act   = ACT_BYTE;
						sbyte = esc[7:0];
					end else if (c != CH_U) begin
						act = ACT_FAIL;
						err = ERR_BAD_ESC;
					end
				end
				MODE_HEX: begin
					if (!hx[4]) begin
						act = ACT_FAIL;
						err = ERR_BAD_HEX;
					end else if (full && is_lo) begin
						act = ACT_FAIL;
						err = ERR_LONE_LOW;
					end else if (full && !is_hi) begin
						act = ACT_CP;
					end
				end
				MODE_LOW_HEX: begin
					if (!hx[4] || (full && !is_lo)) begin
						act = ACT_FAIL;
						err = ERR_BAD_LOW;
					end else if (full) begin
						act = ACT_CP;
					end
				end
				MODE_LOW_BS: begin
					if (c != CH_BSLASH) begin
						act = ACT_FAIL;
						err = ERR_MISSING_LOW;
					end
				end
				MODE_LOW_U: begin
					if (c != CH_U) begin
						act = ACT_FAIL;
						err = ERR_MISSING_LOW;
					end
				end
				default: begin
					if (c == CH_QUOTE) begin
						act = ACT_CLOSE;
					end else if (c < CH_SPACE) begin
						act = ACT_FAIL;
						err = ERR_CONTROL;
					end else if (c != CH_BSLASH) begin
						act = ACT_BYTE;
					end
				end
			endcase
		end
	end

	always_comb begin
		grp = '0;
		unique case (act)
			ACT_NONE: grp.valid = 1'b0;
			ACT_BYTE: begin
				grp.valid    = 1'b1;
				grp.kind     = KIND_DATA;
				grp.bytes[0] = sbyte;
			end
			ACT_CP: begin
				grp.valid    = 1'b1;
				grp.kind     = KIND_DATA;
				grp.last_idx = enc.last_idx;
				grp.bytes    = enc.bytes;
			end
			ACT_CLOSE: begin
				grp.valid = 1'b1;
				grp.kind  = KIND_CLOSE;
			end
			ACT_FAIL: begin
				grp.valid = 1'b1;
				grp.kind  = KIND_ERROR;
				grp.code  = err;
			end
			default: grp.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cnt_q  <= '0;
			acc_q  <= '0;
			hi_q   <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			hi_q   <= hi_d;
		end
	end

endmodule

>>> rtl/jsu_emit.sv
// result register: holds one result group and sends it one beat at a time
// depends on jsu_pkg and json_string_unescape_utf8_assert.svh
`include "json_string_unescape_utf8_assert.svh"
module jsu_emit import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  jsu_group_t grp,
	output logic       free,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output jsu_out_t   rsp
);

	logic       valid_q;
	logic [1:0] idx_q;
	jsu_group_t grp_q;
	logic       at_last, fire;

	assign at_last   = (idx_q == grp_q.last_idx);
	assign fire      = valid_q && !rsp_stall;
	// the group register can take a new group when it is empty or once its final beat leaves
	assign free      = !valid_q || (fire && at_last);
	assign rsp_valid = valid_q;

	assign rsp.out_byte   = grp_q.bytes[idx_q];
	assign rsp.kind       = grp_q.kind;
	assign rsp.error_code = grp_q.code;
	assign rsp.last       = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= grp.valid;
			idx_q   <= '0;
		end else if (fire && at_last) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) grp_q <= grp;
	end

	`JSU_ASSERT_NOW(a_load_when_free, load && valid_q, !rsp_stall && at_last, "group overwritten before its last beat left")
	`JSU_ASSERT_NOW(a_single_nondata, rsp_valid && rsp.kind != KIND_DATA, rsp.last && rsp.out_byte == 8'd0, "close or error beat is not a lone zero-byte beat")
	`JSU_ASSERT_NOW(a_code_only_on_error, rsp_valid && rsp.kind != KIND_ERROR, rsp.error_code == ERR_NONE, "error code on a non-error beat")
	`JSU_ASSERT_NEXT(a_multi_step, fire && !at_last && !load, valid_q && idx_q == $past(idx_q) + 2'd1, "multi-byte group did not advance to its next byte")

endmodule

>>> rtl/json_string_unescape_utf8.sv
// json string body unescaper producing utf-8, top level
// depends on jsu_pkg, jsu_decode and jsu_emit
//
// req channel: one raw string-body byte per beat (bytes after the opening
// quote), or a beat with input_ended set when the text runs out.
// rsp channel: one result per beat: a decoded utf-8 byte, a string-closed
// marker, or one error with its code; last marks the final result of an item.
// an item is registered on acceptance, decoded combinationally into a group
// of up to four results, and that group is loaded into the result register
// once that register is free; results are offered from the result register.
// throughput: one item per cycle while rsp_stall is low and each item gives
// at most one result; a \u escape that ends in a 2-, 3- or 4-byte utf-8
// sequence holds the result register until its last byte leaves. rate is set
// by the single result register, which sends one beat a cycle unless stalled.
// after a closing quote, an end of input or an error, the parser starts a new
// string with the next item.
// reset clears the parser state and empties both registers; no clearing pass.
// while rsp_stall is high the offered result holds and req_stall rises once
// the input register holds an item that cannot move on.
module json_string_unescape_utf8 import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  jsu_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output jsu_out_t rsp
);

	logic       valid_s1;
	jsu_in_t    item_s1;
	logic       free, step;
	jsu_group_t grp;

	assign step      = valid_s1 && free;
	assign req_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) item_s1 <= req;
	end

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.grp    (grp)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.grp       (grp),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> sim/tb_json_string_unescape_utf8.sv
// self-checking testbench for the json string unescaper (json_string_unescape_utf8)
// predicts every result beat in-line from the raw byte stream; needs jsu_pkg and the rtl
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8 import jsu_pkg::*;;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 120;
	localparam int END_WAIT   = 16;

	localparam logic [7:0] LTR_B  = 8'h62;
	localparam logic [7:0] LTR_F  = 8'h66;
	localparam logic [7:0] LTR_N  = 8'h6E;
	localparam logic [7:0] LTR_R  = 8'h72;
	localparam logic [7:0] LTR_T  = 8'h74;
	localparam logic [7:0] BS_CH  = 8'h08;
	localparam logic [7:0] FF_CH  = 8'h0C;
	localparam logic [7:0] LF_CH  = 8'h0A;
	localparam logic [7:0] CR_CH  = 8'h0D;
	localparam logic [7:0] TAB_CH = 8'h09;
	localparam logic [7:0][7:0] ESC_SET =
		{CH_QUOTE, CH_BSLASH, CH_SLASH, LTR_B, LTR_F, LTR_N, LTR_R, LTR_T};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	jsu_in_t  req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	jsu_out_t rsp;

	// parser state as the predictor sees it
	jsu_mode_t   st_mode;
	logic [1:0]  st_digits;
	logic [15:0] st_acc;
	logic [9:0]  st_high;

	jsu_out_t item_out[$];
	jsu_out_t expected_out[$];
	jsu_in_t  frag[$];

	int send_gap_max = 0;
	int rsp_gap_max = 0;
	int hold_ask = 0;
	int beats_in = 0;
	int beats_out = 0;
	int closes_seen = 0;
	int errors_seen = 0;
	int mismatches = 0;

	json_string_unescape_utf8 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic void clear_parser();
		st_mode = MODE_PLAIN;
		st_digits = '0;
		st_acc = '0;
		st_high = '0;
	endfunction

	function automatic void add_out(input logic [7:0] b, input jsu_kind_t k, input jsu_err_t e);
		jsu_out_t r;
		r.out_byte = b;
		r.kind = k;
		r.error_code = e;
		r.last = 1'b0;
		item_out = {item_out, r};
	endfunction

	function automatic void fail_with(input jsu_err_t e);
		clear_parser();
		add_out(8'h00, KIND_ERROR, e);
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void add_codepoint(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_out(cp[7:0], KIND_DATA, ERR_NONE);
		end else if (cp < 21'h800) begin
			add_out(8'hC0 | 8'(cp >> 6), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end else if (cp < 21'h10000) begin
			add_out(8'hE0 | 8'(cp >> 12), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end else begin
			add_out(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA, ERR_NONE);
			add_out(8'h80 | 8'(cp & 21'h3F), KIND_DATA, ERR_NONE);
		end
	endfunction

	function automatic void predict_unescape(input jsu_in_t it);
		logic [7:0]  c;
		int          d;
		logic [15:0] v;
		logic [20:0] cp;
		jsu_out_t    r;
		c = it.in_byte;
		item_out.delete();
		if (it.input_ended) begin
			case (st_mode)
				MODE_ESC:                fail_with(ERR_TRUNC_ESC);
				MODE_HEX:                fail_with(ERR_TRUNC_HEX);
				MODE_LOW_BS, MODE_LOW_U: fail_with(ERR_MISSING_LOW);
				MODE_LOW_HEX:            fail_with(ERR_BAD_LOW);
				default:                 fail_with(ERR_UNTERM);
			endcase
		end else begin
			case (st_mode)
				MODE_ESC: begin
					st_mode = MODE_PLAIN;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: add_out(c, KIND_DATA, ERR_NONE);
						LTR_B: add_out(BS_CH, KIND_DATA, ERR_NONE);
						LTR_F: add_out(FF_CH, KIND_DATA, ERR_NONE);
						LTR_N: add_out(LF_CH, KIND_DATA, ERR_NONE);
						LTR_R: add_out(CR_CH, KIND_DATA, ERR_NONE);
						LTR_T: add_out(TAB_CH, KIND_DATA, ERR_NONE);
						CH_U: begin
							st_mode = MODE_HEX;
							st_digits = '0;
							st_acc = '0;
						end
						default: fail_with(ERR_BAD_ESC);
					endcase
				end
				MODE_HEX, MODE_LOW_HEX: begin
					d = hex_nibble(c);
					if (d < 0) begin
						if (st_mode == MODE_HEX) fail_with(ERR_BAD_HEX);
						else fail_with(ERR_BAD_LOW);
					end else begin
						v = {st_acc[11:0], d[3:0]};
						if (st_digits != 2'd3) begin
							st_acc = v;
							st_digits = st_digits + 2'd1;
						end else if (st_mode == MODE_HEX) begin
							if (v >= 16'hD800 && v <= 16'hDBFF) begin
								// high half: wait for the low surrogate escape
								st_high = v[9:0];
								st_mode = MODE_LOW_BS;
								st_digits = '0;
								st_acc = '0;
							end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
								fail_with(ERR_LONE_LOW);
							end else begin
								clear_parser();
								add_codepoint({5'd0, v});
							end
						end else if (v < 16'hDC00 || v > 16'hDFFF) begin
							fail_with(ERR_BAD_LOW);
						end else begin
							cp = 21'h10000 + {1'b0, st_high, v[9:0]};
							clear_parser();
							add_codepoint(cp);
						end
					end
				end
				MODE_LOW_BS: begin
					if (c != CH_BSLASH) fail_with(ERR_MISSING_LOW);
					else st_mode = MODE_LOW_U;
				end
				MODE_LOW_U: begin
					if (c != CH_U) begin
						fail_with(ERR_MISSING_LOW);
					end else begin
						st_mode = MODE_LOW_HEX;
						st_digits = '0;
						st_acc = '0;
					end
				end
				default: begin
					if (c == CH_QUOTE) begin
						clear_parser();
						add_out(8'h00, KIND_CLOSE, ERR_NONE);
					end else if (c < CH_SPACE) begin
						fail_with(ERR_CONTROL);
					end else if (c == CH_BSLASH) begin
						st_mode = MODE_ESC;
					end else begin
						add_out(c, KIND_DATA, ERR_NONE);
					end
				end
			endcase
		end
		if (item_out.size() > 0) begin
			r = item_out.pop_back();
			r.last = 1'b1;
			item_out = {item_out, r};
		end
		expected_out = {expected_out, item_out};
		item_out.delete();
	endfunction

	// ---------------- request side ----------------

	task automatic send_beat(input logic [7:0] b, input logic ended);
		jsu_in_t it;
		int      gap;
		it.in_byte = b;
		it.input_ended = ended;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_unescape(it);
		beats_in++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_out.size() != 0);
	endtask

	task automatic send_frag();
		jsu_in_t it;
		while (frag.size() > 0) begin
			it = frag.pop_front();
			send_beat(it.in_byte, it.input_ended);
		end
	endtask

	function automatic void frag_byte(input logic [7:0] c);
		jsu_in_t it;
		it.in_byte = c;
		it.input_ended = 1'b0;
		frag = {frag, it};
	endfunction

	function automatic void frag_end();
		jsu_in_t it;
		it.in_byte = 8'($urandom);
		it.input_ended = 1'b1;
		frag = {frag, it};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return "0" + 8'(n);
		if ($urandom_range(0, 1) == 0) return "a" + 8'(n - 4'd10);
		return "A" + 8'(n - 4'd10);
	endfunction

	function automatic void frag_u(input logic [15:0] v);
		frag_byte(CH_BSLASH);
		frag_byte(CH_U);
		for (int i = 3; i >= 0; i--) frag_byte(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void frag_partial_hex();
		int k;
		k = $urandom_range(0, 3);
		frag_byte(CH_BSLASH);
		frag_byte(CH_U);
		for (int i = 0; i < k; i++) frag_byte(hex_char(4'($urandom)));
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		do c = 8'($urandom); while (hex_nibble(c) >= 0);
		return c;
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		if (c == CH_U) return 1'b1;
		for (int i = 0; i < 8; i++) if (ESC_SET[i] == c) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [15:0] high_half();
		return 16'($urandom_range('hD800, 'hDBFF));
	endfunction

	// non-surrogate bmp value, spread over the 1-, 2- and 3-byte encodings
	function automatic logic [15:0] bmp_value();
		logic [15:0] v;
		case ($urandom_range(0, 2))
			0: v = 16'($urandom_range(0, 'h7F));
			1: v = 16'($urandom_range('h80, 'h7FF));
			default: begin
				v = 16'($urandom_range('h800, 'hFFFF));
				if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
			end
		endcase
		return v;
	endfunction

	function automatic void add_good_frag();
		logic [7:0] c;
		int         sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
			frag_byte(c);
		end else if (sel < 7) begin
			frag_byte(CH_BSLASH);
			frag_byte(ESC_SET[$urandom_range(0, 7)]);
		end else if (sel < 9) begin
			frag_u(bmp_value());
		end else begin
			frag_u(high_half());
			frag_u(16'($urandom_range('hDC00, 'hDFFF)));
		end
	endfunction

	function automatic void add_fault_frag();
		logic [7:0]  c;
		logic [15:0] v;
		int          start;
		int          cut;
		case ($urandom_range(0, 7))
			0: frag_byte(8'($urandom_range(0, 31)));
			1: begin
				do c = 8'($urandom); while (is_escape_letter(c));
				frag_byte(CH_BSLASH);
				frag_byte(c);
			end
			2: begin
				frag_partial_hex();
				frag_byte(non_hex_byte());
			end
			3: frag_u(16'($urandom_range('hDC00, 'hDFFF)));
			4: begin
				frag_u(high_half());
				do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
				frag_u(v);
			end
			5: begin
				frag_u(high_half());
				if ($urandom_range(0, 1) == 0) begin
					do c = 8'($urandom); while (c == CH_BSLASH);
					frag_byte(c);
				end else begin
					do c = 8'($urandom); while (c == CH_U);
					frag_byte(CH_BSLASH);
					frag_byte(c);
				end
			end
			6: begin
				frag_u(high_half());
				frag_partial_hex();
				frag_byte(non_hex_byte());
			end
			default: begin
				// text runs out just before or somewhere inside an escape
				start = frag.size();
				if ($urandom_range(0, 1) == 0) begin
					frag_u(bmp_value());
				end else begin
					frag_u(high_half());
					frag_u(16'($urandom_range('hDC00, 'hDFFF)));
				end
				cut = $urandom_range(start, frag.size() - 1);
				while (frag.size() > cut) frag.delete(frag.size() - 1);
				frag_end();
			end
		endcase
	endfunction

	task automatic send_random_string();
		int nseg;
		int fault_at;
		nseg = $urandom_range(1, 6);
		fault_at = -1;
		if ($urandom_range(0, 99) < 25) fault_at = $urandom_range(0, nseg - 1);
		frag.delete();
		for (int s = 0; s < nseg; s++) begin
			if (s == fault_at) begin
				add_fault_frag();
				send_frag();
				return;
			end
			add_good_frag();
		end
		if ($urandom_range(0, 9) == 0) frag_end();
		else frag_byte(CH_QUOTE);
		send_frag();
	endtask

	// ---------------- result side ----------------

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result(input jsu_out_t got);
		jsu_out_t want;
		beats_out++;
		if (got.kind == KIND_CLOSE) closes_seen++;
		if (got.kind == KIND_ERROR) errors_seen++;
		if (expected_out.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
			mismatches++;
		end else begin
			want = expected_out.pop_front();
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("kind", 8'(want.kind), 8'(got.kind));
			compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
			compare_field("last", 8'(want.last), 8'(got.last));
		end
	endfunction

	initial begin : rsp_side
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				check_result(rsp);
				stall_left = $urandom_range(0, rsp_gap_max);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_stall <= (stall_left > 0) || (hold_left > 0);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("%0t: timeout, no beat moved for %0d cycles, %0d results outstanding",
					$time, idle, expected_out.size());
				$display("tb_json_string_unescape_utf8 failed");
				$finish;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_plain_and_control();
		send_text(" ~");
		send_beat(8'h7F, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(CH_QUOTE, 1'b0);
		send_beat(8'h1F, 1'b0);
		send_beat(8'h00, 1'b0);
	endtask

	task automatic test_simple_escapes();
		send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
		send_text("\\q");
	endtask

	task automatic test_unicode_escapes();
		send_text("\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uD800\\uDC00\\uDBFF\\udfff\"");
	endtask

	task automatic test_malformed();
		send_text("\\u12G");
		send_text("\\uDC00");
		send_text("\\uD800\\u0041");
		send_text("\\uD800x");
		send_text("\\uD800\\x");
		send_text("\\uD800\\u12z");
	endtask

	task automatic test_truncation();
		send_end();
		send_text("\\");
		send_end();
		send_text("\\u0");
		send_end();
		send_text("\\uD800");
		send_end();
		send_text("\\uD800\\");
		send_end();
		send_text("\\uD800\\uDC");
		send_end();
	endtask

	// receiver holds off while the sender keeps pushing multi-byte escapes
	task automatic test_backpressure();
		send_gap_max = 0;
		rsp_gap_max = 0;
		hold_ask++;
		send_text("\\uD83D\\uDE00\\uFFFF\\u07FFab\"");
		wait_drained();
	endtask

	task automatic test_random_strings(input int gap_in, input int gap_out, input int count);
		int start;
		start = beats_in;
		send_gap_max = gap_in;
		rsp_gap_max = gap_out;
		while (beats_in - start < count) begin
			if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), $urandom_range(0, 15) == 0);
			else send_random_string();
		end
	endtask

	initial begin
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_max = 3;
		rsp_gap_max = 3;
		test_plain_and_control();
		test_simple_escapes();
		test_unicode_escapes();
		test_malformed();
		test_truncation();
		wait_drained();
		test_backpressure();
		test_random_strings(8, 8, 15);
		wait_drained();
		test_random_strings(0, 0, 15);
		test_random_strings(8, 0, 15);
		wait_drained();
		test_random_strings(0, 8, 15);
		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		$display("run covered %0d input beats and %0d result beats (%0d closes, %0d errors)",
			beats_in, beats_out, closes_seen, errors_seen);
		$display("escapes, surrogate pairs, malformed and truncated strings, long result stall");
		if (mismatches == 0 && expected_out.size() == 0) begin
			$display("tb_json_string_unescape_utf8 passed");
		end else begin
			$display("tb_json_string_unescape_utf8 failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_utf8.sv
sim/tb_json_string_unescape_utf8.sv
